// File: rtl/eqbr_pkg.sv
// Shared types and constants for the EPS QoS bit-rate encoder.
package eqbr_pkg;

    // Clamped kbps value: anything above TOP_KBPS is held at TOP_KBPS + 1.
    localparam int KBPS_W = 24;

    localparam logic [KBPS_W-1:0] MBPS     = KBPS_W'(1024);
    localparam logic [KBPS_W-1:0] TOP_KBPS = KBPS_W'(10 * 1000 * 1024);
    localparam logic [KBPS_W-1:0] SAT_KBPS = TOP_KBPS + KBPS_W'(1);

    // Octet codes at the step boundaries and gaps
    localparam logic [7:0] BR_STEP8_BASE  = 8'b0100_0000;
    localparam logic [7:0] BR_STEP64_BASE = 8'b1000_0000;
    localparam logic [7:0] BR_GAP_568     = 8'b0111_1111;
    localparam logic [7:0] BR_EXTENDED    = 8'b1111_1110;
    localparam logic [7:0] EX_STEP1M_BASE = 8'b0100_1010;
    localparam logic [7:0] EX_STEP2M_BASE = 8'b1011_1010;
    localparam logic [7:0] EX_EXTENDED2   = 8'b1111_1010;
    localparam logic [7:0] EX2_STEP10M    = 8'b0011_1101;
    localparam logic [7:0] EX2_STEP100M   = 8'b1010_0001;
    localparam logic [7:0] EX2_SATURATED  = 8'b1111_0110;

    localparam logic [KBPS_W-1:0] EX_OFFSET_KBPS = KBPS_W'(8600);

    // Octet counts
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_BASE = 2'd1;
    localparam logic [1:0] LEN_EXT  = 2'd2;
    localparam logic [1:0] LEN_EXT2 = 2'd3;

    // Reciprocal multipliers: x/100 == (x*5243)>>19 for x < 43699,
    // y/10 == (y*205)>>11 for y < 1029.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [7:0]  RECIP_10  = 8'd205;

    typedef struct packed {
        logic [1:0] octets_used;
        logic [7:0] extended2_octet;
        logic [7:0] extended_octet;
        logic [7:0] rate_octet;
    } eqbr_result_t;

endpackage

// File: rtl/eqbr_encode.sv
// Combinational piecewise encoder from clamped kbps to the three bit-rate octets.
module eqbr_encode
    import eqbr_pkg::*;
(
    input  logic [KBPS_W-1:0] kbps,
    output eqbr_result_t      result
);

    logic [KBPS_W-1:0] d_step8;
    logic [KBPS_W-1:0] d_step64;
    logic [KBPS_W-1:0] d_step100k;
    logic [KBPS_W-1:0] d_step1m;
    logic [KBPS_W-1:0] d_step2m;
    logic [KBPS_W-1:0] d_step4m;
    logic [KBPS_W-1:0] d_step10m;
    logic [KBPS_W-1:0] d_step100m;
    logic [25:0]       prod_100k;
    logic [17:0]       prod_10m;
    logic [26:0]       prod_100m;

    assign d_step8    = kbps - KBPS_W'(64);
    assign d_step64   = kbps - KBPS_W'(576);
    assign d_step100k = kbps - EX_OFFSET_KBPS;
    assign d_step1m   = kbps - KBPS_W'(16) * MBPS;
    assign d_step2m   = kbps - KBPS_W'(128) * MBPS;
    assign d_step4m   = kbps - KBPS_W'(256) * MBPS;
    assign d_step10m  = kbps - KBPS_W'(500) * MBPS;
    assign d_step100m = kbps - KBPS_W'(1500) * MBPS;

    // divide by 100 kbps, 10 Mbps and 100 Mbps via reciprocals
    assign prod_100k = 26'(d_step100k[12:0]) * 26'(RECIP_100);
    assign prod_10m  = 18'(d_step10m[19:10]) * 18'(RECIP_10);
    assign prod_100m = 27'(d_step100m[23:10]) * 27'(RECIP_100);

    always_comb
    begin
        result = '0;
        if (kbps == '0)
        begin
            result.octets_used = LEN_NONE;
        end
        else if (kbps <= KBPS_W'(63))
        begin
            result.rate_octet  = kbps[7:0];
            result.octets_used = LEN_BASE;
        end
        else if (kbps <= KBPS_W'(568))
        begin
            result.rate_octet  = BR_STEP8_BASE + d_step8[10:3];
            result.octets_used = LEN_BASE;
        end
        else if (kbps < KBPS_W'(576))
        begin
            result.rate_octet  = BR_GAP_568;
            result.octets_used = LEN_BASE;
        end
        else if (kbps <= KBPS_W'(8640))
        begin
            result.rate_octet  = BR_STEP64_BASE + d_step64[13:6];
            result.octets_used = LEN_BASE;
        end
        else if (kbps < KBPS_W'(8700))
        begin
            result.rate_octet  = BR_EXTENDED;
            result.octets_used = LEN_BASE;
        end
        else
        begin
            result.rate_octet = BR_EXTENDED;
            if (kbps <= KBPS_W'(16000))
            begin
                result.extended_octet = {1'b0, prod_100k[25:19]};
                result.octets_used    = LEN_EXT;
            end
            else if (kbps < KBPS_W'(17) * MBPS)
            begin
                result.extended_octet = EX_STEP1M_BASE;
                result.octets_used    = LEN_EXT;
            end
            else if (kbps <= KBPS_W'(128) * MBPS)
            begin
                result.extended_octet = EX_STEP1M_BASE + d_step1m[17:10];
                result.octets_used    = LEN_EXT;
            end
            else if (kbps < KBPS_W'(130) * MBPS)
            begin
                result.extended_octet = EX_STEP2M_BASE;
                result.octets_used    = LEN_EXT;
            end
            else if (kbps <= KBPS_W'(256) * MBPS)
            begin
                result.extended_octet = EX_STEP2M_BASE + d_step2m[18:11];
                result.octets_used    = LEN_EXT;
            end
            else if (kbps < KBPS_W'(260) * MBPS)
            begin
                result.extended_octet = EX_EXTENDED2;
                result.octets_used    = LEN_EXT;
            end
            else
            begin
                result.extended_octet = EX_EXTENDED2;
                result.octets_used    = LEN_EXT2;
                if (kbps <= KBPS_W'(500) * MBPS)
                    result.extended2_octet = d_step4m[19:12];
                else if (kbps < KBPS_W'(510) * MBPS)
                    result.extended2_octet = EX2_STEP10M;
                else if (kbps <= KBPS_W'(1500) * MBPS)
                    result.extended2_octet = EX2_STEP10M + {1'b0, prod_10m[17:11]};
                else if (kbps < KBPS_W'(1600) * MBPS)
                    result.extended2_octet = EX2_STEP100M;
                else if (kbps <= TOP_KBPS)
                    result.extended2_octet = EX2_STEP100M + prod_100m[26:19];
                else
                    result.extended2_octet = EX2_SATURATED;
            end
        end
    end

endmodule

// File: rtl/eps_qos_bit_rate_encoder_core.sv
// Top level of the EPS QoS bit-rate encoder: input register, encoder, output register.
// An accepted word is registered in stage 1, encoded, and its result registered in stage 2.
// Throughput: one word per cycle while m_axis_tready is high; an empty stage 1 still fills.
// Back-pressure: s_axis_tready drops only while both stages hold words and m_axis_tready is low.
// Reset: rst_n asynchronous, active low; clears both stage valid flags, payloads are not reset.
// No configuration and no stored state beyond the two stages.
module eps_qos_bit_rate_encoder_core
    import eqbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] rate_bps
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] rate_octet, [15:8] extended_octet,
                                        // [23:16] extended2_octet, [25:24] octets_used,
                                        // [31:26] zero
);

    // Stage 1: kbps, clamped into KBPS_W bits
    logic              in_valid_reg;
    logic [KBPS_W-1:0] kbps_reg;
    logic [KBPS_W-1:0] kbps_next;
    logic              in_advance;

    // Stage 2: result word
    logic              out_valid_reg;
    eqbr_result_t      result_reg;
    eqbr_result_t      result_next;
    logic              out_free;

    logic [53:0]       kbps_full;

    // Dropping the low 10 bits gives kbps; anything past the top rate is clamped
    // to one above it so the encoder saturates.
    assign kbps_full = s_axis_tdata[63:10];
    assign kbps_next = ((|kbps_full[53:KBPS_W]) || (kbps_full[KBPS_W-1:0] > TOP_KBPS))
                       ? SAT_KBPS : kbps_full[KBPS_W-1:0];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_advance    = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            kbps_reg <= kbps_next;
    end

    eqbr_encode u_encode
    (
        .kbps   (kbps_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, result_reg};

`ifndef SYNTHESIS
    // Stall only with both stages full and the master side holding off
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // A word in stage 1 moves to the output at the next edge when the output is free
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_advance |=> out_valid_reg)
        else $error("stage 1 word lost on advance");

    // No octets used means all octets zero
    a_len_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.octets_used == LEN_NONE) |->
        (result_reg.rate_octet == '0 && result_reg.extended_octet == '0
         && result_reg.extended2_octet == '0))
        else $error("octets present with zero length");

    // Base octet only: extended octets stay zero
    a_len_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.octets_used == LEN_BASE) |->
        (result_reg.extended_octet == '0 && result_reg.extended2_octet == '0))
        else $error("extended octets set with base length");

    // Second extended octet only with full length and the extension marks
    a_ext2_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.extended2_octet != '0) |->
        (result_reg.octets_used == LEN_EXT2 && result_reg.rate_octet == BR_EXTENDED
         && result_reg.extended_octet == EX_EXTENDED2))
        else $error("second extended octet without extension marks");
`endif

endmodule

// File: bench/eps_qos_bit_rate_encoder_core_tb.sv
// Self-checking bench for the EPS QoS bit-rate encoder core: directed edges, random rates, stalls.
module eps_qos_bit_rate_encoder_core_tb
    import eqbr_pkg::*;
();

    // kbps per Mbps as the encoder counts it
    localparam logic [63:0] KB_PER_MB   = 64'd1024;
    localparam logic [63:0] EX_BASE_KB  = 64'd8600;
    localparam logic [63:0] TOP_RATE_KB = 64'd10 * 64'd1000 * KB_PER_MB;
    localparam int          RANDOM_WORDS = 750;

    // Holds the expected octets of every accepted rate, oldest first.
    class octet_scoreboard;
        eqbr_result_t pending_octets[$];
        logic [63:0]  pending_rates[$];
        int           errors = 0;

        // Piecewise encoding of the kbps value into base/extended/extended2 octets.
        static function eqbr_result_t encode_rate(input logic [63:0] rate);
            logic [63:0]  k;
            logic [63:0]  v;
            eqbr_result_t r;
            k = rate >> 10;
            r = '0;
            v = '0;
            if (k == 0)
            begin
                r.octets_used = LEN_NONE;
            end
            else if (k <= 63)
            begin
                r.rate_octet  = k[7:0];
                r.octets_used = LEN_BASE;
            end
            else if (k <= 568)
            begin
                v = (k - 64) / 8 + 64'(BR_STEP8_BASE);
                r.rate_octet  = v[7:0];
                r.octets_used = LEN_BASE;
            end
            else if (k < 576)
            begin
                r.rate_octet  = BR_GAP_568;
                r.octets_used = LEN_BASE;
            end
            else if (k <= 8640)
            begin
                v = (k - 576) / 64 + 64'(BR_STEP64_BASE);
                r.rate_octet  = v[7:0];
                r.octets_used = LEN_BASE;
            end
            else if (k < 8700)
            begin
                // gap above 8640 kbps: extended marker but only one octet counted
                r.rate_octet  = BR_EXTENDED;
                r.octets_used = LEN_BASE;
            end
            else
            begin
                r.rate_octet = BR_EXTENDED;
                r.octets_used = LEN_EXT;
                if (k <= 16000)
                begin
                    v = (k - EX_BASE_KB) / 100;
                    r.extended_octet = v[7:0];
                end
                else if (k < 17 * KB_PER_MB)
                begin
                    r.extended_octet = EX_STEP1M_BASE;
                end
                else if (k <= 128 * KB_PER_MB)
                begin
                    v = (k - 16 * KB_PER_MB) / KB_PER_MB + 64'(EX_STEP1M_BASE);
                    r.extended_octet = v[7:0];
                end
                else if (k < 130 * KB_PER_MB)
                begin
                    r.extended_octet = EX_STEP2M_BASE;
                end
                else if (k <= 256 * KB_PER_MB)
                begin
                    v = (k - 128 * KB_PER_MB) / (2 * KB_PER_MB) + 64'(EX_STEP2M_BASE);
                    r.extended_octet = v[7:0];
                end
                else if (k < 260 * KB_PER_MB)
                begin
                    r.extended_octet = EX_EXTENDED2;
                end
                else
                begin
                    r.extended_octet = EX_EXTENDED2;
                    r.octets_used    = LEN_EXT2;
                    if (k <= 500 * KB_PER_MB)
                        v = (k - 256 * KB_PER_MB) / (4 * KB_PER_MB);
                    else if (k < 510 * KB_PER_MB)
                        v = 64'(EX2_STEP10M);
                    else if (k <= 1500 * KB_PER_MB)
                        v = (k - 500 * KB_PER_MB) / (10 * KB_PER_MB) + 64'(EX2_STEP10M);
                    else if (k < 1600 * KB_PER_MB)
                        v = 64'(EX2_STEP100M);
                    else if (k <= TOP_RATE_KB)
                        v = (k - 1500 * KB_PER_MB) / (100 * KB_PER_MB) + 64'(EX2_STEP100M);
                    else
                        v = 64'(EX2_SATURATED);
                    r.extended2_octet = v[7:0];
                end
            end
            return r;
        endfunction

        function void note_rate(input logic [63:0] rate);
            pending_octets.push_back(encode_rate(rate));
            pending_rates.push_back(rate);
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(input logic [31:0] word);
            eqbr_result_t got;
            eqbr_result_t want;
            logic [63:0]  rate;
            got = eqbr_result_t'(word[25:0]);
            if (pending_octets.size() == 0)
            begin
                report($sformatf("unexpected word %h", word));
            end
            else
            begin
                want = pending_octets.pop_front();
                rate = pending_rates.pop_front();
                if (got.rate_octet != want.rate_octet)
                    report($sformatf("rate %h: rate_octet %h, want %h",
                                     rate, got.rate_octet, want.rate_octet));
                if (got.extended_octet != want.extended_octet)
                    report($sformatf("rate %h: extended_octet %h, want %h",
                                     rate, got.extended_octet, want.extended_octet));
                if (got.extended2_octet != want.extended2_octet)
                    report($sformatf("rate %h: extended2_octet %h, want %h",
                                     rate, got.extended2_octet, want.extended2_octet));
                if (got.octets_used != want.octets_used)
                    report($sformatf("rate %h: octets_used %0d, want %0d",
                                     rate, got.octets_used, want.octets_used));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    bit              idle_on = 1'b1;
    octet_scoreboard sb = new;

    eps_qos_bit_rate_encoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Region edges in kbps: each entry starts the zero region, a step, a gap or saturation.
    localparam int unsigned N_EDGES = 18;
    localparam logic [31:0] KB_EDGES [N_EDGES] = '{
        32'd0, 32'd1, 32'd64, 32'd569, 32'd576, 32'd8641, 32'd8700, 32'd16001,
        32'd17408, 32'd131073, 32'd133120, 32'd262145, 32'd266240, 32'd512001,
        32'd522240, 32'd1536001, 32'd1638400, 32'd10240001
    };

    // Random rate: mostly a random kbps inside a random region, some near edges,
    // some wholly random words to toggle the upper bits.
    function automatic logic [63:0] random_rate();
        logic [63:0] k;
        int unsigned pick;
        int unsigned region;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return {$urandom, $urandom};
        if (pick == 1)
        begin
            k = 64'(KB_EDGES[$urandom_range(0, N_EDGES - 1)]) + 64'($urandom_range(0, 2)) - 64'd1;
        end
        else
        begin
            region = $urandom_range(0, N_EDGES - 1);
            if (region == N_EDGES - 1)
                k = 64'(KB_EDGES[region]) + 64'($urandom_range(0, 32'h7fff_ffff));
            else
                k = 64'(KB_EDGES[region])
                    + 64'($urandom_range(0, KB_EDGES[region + 1] - KB_EDGES[region] - 1));
        end
        return {k[53:0], 10'($urandom)};
    endfunction

    // Offer one rate word, with an optional idle burst first; returns once accepted.
    task automatic send_rate(input logic [63:0] rate);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rate;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_rate(rate);
    endtask

    task automatic send_kbps(input logic [63:0] kbps);
        send_rate({kbps[53:0], 10'($urandom)});
    endtask

    // Receiver: random stall bursts while idling is on, otherwise always ready.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Every word leaving the block is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: below 1 kbps, every step edge, one value inside each gap, saturation.
        send_rate(64'd0);
        send_rate(64'd1023);
        send_rate(64'd1024);
        send_kbps(64'd63);
        send_kbps(64'd64);
        send_kbps(64'd568);
        send_kbps(64'd569);
        send_kbps(64'd576);
        send_kbps(64'd8640);
        send_kbps(64'd8641);
        send_kbps(64'd8700);
        send_kbps(64'd16000);
        send_kbps(64'd16001);
        send_kbps(64'd17408);
        send_kbps(64'd131073);
        send_kbps(64'd133120);
        send_kbps(64'd262145);
        send_kbps(64'd266240);
        send_kbps(64'd512001);
        send_kbps(64'd522240);
        send_kbps(64'd1536001);
        send_kbps(64'd1638400);
        send_kbps(TOP_RATE_KB);
        send_kbps(TOP_RATE_KB + 64'd1);
        send_rate({64{1'b1}});

        // Random part: idling in stretches, none in the closing hundred words.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            idle_on = ((i / 60) % 3 != 2) && (i < RANDOM_WORDS - 100);
            send_rate(random_rate());
        end
        idle_on = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending_octets.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("eps_qos_bit_rate_encoder_core_tb: PASS");
        else
            $display("eps_qos_bit_rate_encoder_core_tb: FAIL");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("eps_qos_bit_rate_encoder_core_tb: FAIL");
        $finish;
    end

endmodule
